@@ src/spct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_pkg
// Shared widths, defaults and operation codes of the sync point counter table.
// ----------------------------------------------------------------------------
package spct_pkg;

  localparam int MODE_W  = 3;
  localparam int INDEX_W = 5;
  localparam int DATA_W  = 32;

  localparam int DEF_NUM_POINTS    = 32;
  localparam int DEF_NUM_BASES     = 8;
  localparam int DEF_COMPARE_WIDTH = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INCR      = 3'd0,
    MODE_SET_COUNT = 3'd1,
    MODE_SET_THRES = 3'd2,
    MODE_ADD_BASE  = 3'd3,
    MODE_SET_BASE  = 3'd4,
    MODE_READ      = 3'd5
  } mode_t;

endpackage

@@ src/spct_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_req_if
// Request channel: operation, index and value, with valid/ready.
// ----------------------------------------------------------------------------
interface spct_req_if;
  import spct_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [INDEX_W-1:0] index;
  logic [DATA_W-1:0]  value;

  modport source (output valid, mode, index, value, input ready);
  modport sink   (input valid, mode, index, value, output ready);
endinterface

@@ src/spct_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_rsp_if
// Response channel: entry contents and status flags, with valid/ready.
// ----------------------------------------------------------------------------
interface spct_rsp_if;
  import spct_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] counter_value;
  logic [DATA_W-1:0] threshold_value;
  logic [DATA_W-1:0] base_value;
  logic              reached;
  logic              irq_request;
  logic              bad_index;

  modport source (output valid, counter_value, threshold_value, base_value, reached,
                  irq_request, bad_index, input ready);
  modport sink   (input valid, counter_value, threshold_value, base_value, reached,
                  irq_request, bad_index, output ready);
endinterface

@@ src/spct_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sync_point_counter_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_point_counter_table
// Table of sync point counters and thresholds plus a table of base values.
// ----------------------------------------------------------------------------
// Each request beat names an operation, an index and a value. The block reads
// the entry from its memories, applies the operation, writes changes back and
// returns the entry after the operation with the windowed threshold-reached
// flag, an interrupt request and an index error flag. One request is in work at
// a time: the memory read is registered when it is accepted, the modify and
// write-back follow in the work state, and a response not yet taken stalls it.
// A new request is accepted while a finished response still waits. Entries read
// as zero after reset through per-entry valid bits, so no clearing pass is run.
// ----------------------------------------------------------------------------
module sync_point_counter_table #(
  parameter int NUM_POINTS    = spct_pkg::DEF_NUM_POINTS,
  parameter int NUM_BASES     = spct_pkg::DEF_NUM_BASES,
  parameter int COMPARE_WIDTH = spct_pkg::DEF_COMPARE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  spct_req_if.sink    req,
  spct_rsp_if.source  rsp
);
  import spct_pkg::*;

  localparam int PAW = $clog2(NUM_POINTS);
  localparam int BAW = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;
  localparam int CW  = COMPARE_WIDTH;

  typedef enum logic {S_IDLE, S_WORK} state_t;

  state_t state;

  logic [MODE_W-1:0]  mode_q;
  logic [INDEX_W-1:0] index_q;
  logic [DATA_W-1:0]  value_q;

  logic [NUM_POINTS-1:0] pt_valid;
  logic [NUM_BASES-1:0]  base_valid;

  logic                pt_we;
  logic                base_we;
  logic [PAW-1:0]      pt_addr;
  logic [BAW-1:0]      base_addr;
  logic [2*DATA_W-1:0] pt_rdata;
  logic [DATA_W-1:0]   base_rdata;

  logic accept;
  logic advance;
  logic pt_ok;
  logic base_ok;
  logic point_op;
  logic base_op;

  logic [DATA_W-1:0] cur_cnt;
  logic [DATA_W-1:0] cur_thr;
  logic [DATA_W-1:0] cur_base;
  logic [DATA_W-1:0] cnt_next;
  logic [DATA_W-1:0] thr_next;
  logic [DATA_W-1:0] base_next;

  logic [CW-1:0] d_keep;
  logic [CW-1:0] d_incr;
  logic [CW-1:0] d_setc;
  logic [CW-1:0] d_sett;
  logic [CW-1:0] d_sel;
  logic          reached_next;

  assign accept    = req.valid && req.ready;
  assign advance   = (state == S_WORK) && (!rsp.valid || rsp.ready);
  assign req.ready = (state == S_IDLE);

  assign pt_addr   = PAW'(index_q);
  assign base_addr = BAW'(index_q);
  assign pt_ok     = 32'(index_q) < 32'(NUM_POINTS);
  assign base_ok   = 32'(index_q) < 32'(NUM_BASES);

  spct_ram #(.WIDTH(2*DATA_W), .DEPTH(NUM_POINTS), .AW(PAW)) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_addr),
    .wdata ({thr_next, cnt_next}),
    .re    (accept),
    .raddr (PAW'(req.index)),
    .rdata (pt_rdata)
  );

  spct_ram #(.WIDTH(DATA_W), .DEPTH(NUM_BASES), .AW(BAW)) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (base_addr),
    .wdata (base_next),
    .re    (accept),
    .raddr (BAW'(req.index)),
    .rdata (base_rdata)
  );

  // entries never written read as zero
  always_comb begin
    cur_cnt  = pt_valid[pt_addr] ? pt_rdata[DATA_W-1:0] : '0;
    cur_thr  = pt_valid[pt_addr] ? pt_rdata[2*DATA_W-1:DATA_W] : '0;
    cur_base = base_valid[base_addr] ? base_rdata : '0;
  end

  // low bits of threshold minus counter for every outcome, in parallel
  assign d_keep = cur_thr[CW-1:0] - cur_cnt[CW-1:0];
  assign d_incr = cur_thr[CW-1:0] + ~cur_cnt[CW-1:0];
  assign d_setc = cur_thr[CW-1:0] - value_q[CW-1:0];
  assign d_sett = value_q[CW-1:0] - cur_cnt[CW-1:0];

  always_comb begin
    cnt_next  = cur_cnt;
    thr_next  = cur_thr;
    base_next = cur_base;
    d_sel     = d_keep;
    point_op  = 1'b0;
    base_op   = 1'b0;
    case (mode_t'(mode_q))
      MODE_INCR: begin
        cnt_next = cur_cnt + DATA_W'(1);
        d_sel    = d_incr;
        point_op = 1'b1;
      end
      MODE_SET_COUNT: begin
        cnt_next = value_q;
        d_sel    = d_setc;
        point_op = 1'b1;
      end
      MODE_SET_THRES: begin
        thr_next = value_q;
        d_sel    = d_sett;
        point_op = 1'b1;
      end
      MODE_ADD_BASE: begin
        base_next = cur_base + value_q;
        base_op   = 1'b1;
      end
      MODE_SET_BASE: begin
        base_next = value_q;
        base_op   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign reached_next = pt_ok && (d_sel[CW-1] ^ ~|d_sel[CW-2:0]);

  assign pt_we   = advance && point_op && pt_ok;
  assign base_we = advance && base_op && base_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp.valid  <= 1'b0;
      pt_valid   <= '0;
      base_valid <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WORK;
          end
        end
        S_WORK: begin
          if (advance) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (advance) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (pt_we) begin
        pt_valid[pt_addr] <= 1'b1;
      end
      if (base_we) begin
        base_valid[base_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= req.mode;
      index_q <= req.index;
      value_q <= req.value;
    end
    if (advance) begin
      rsp.counter_value   <= pt_ok ? cnt_next : '0;
      rsp.threshold_value <= pt_ok ? thr_next : '0;
      rsp.base_value      <= base_ok ? base_next : '0;
      rsp.reached         <= reached_next;
      rsp.irq_request     <= point_op && reached_next;
      rsp.bad_index       <= base_op ? !base_ok : !pt_ok;
    end
  end

  // assertions
  a_accept_to_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_WORK))
    else $error("accepted beat did not enter work state");

  a_write_in_work: assert property (@(posedge clk) disable iff (rst)
    (pt_we || base_we) |-> (state == S_WORK))
    else $error("memory written outside work state");

  a_irq_reached: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.irq_request) |-> (rsp.reached && !rsp.bad_index))
    else $error("interrupt request without reached entry");

  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_WORK))
    else $error("response raised without work cycle");

endmodule
